// File: hdl/btffa_pkg.sv
// Shared constants, record types, datapath commands and helpers of the boundary-tag allocator.
package btffa_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;
  localparam int MIN_PAYLOAD  = 8;

  localparam int SZ_W      = 16;
  localparam int REQ_W     = SZ_W + 1;
  localparam int GRAIN_SH  = $clog2(ALIGN_BYTES);
  localparam int DEPTH     = ARENA_BYTES / ALIGN_BYTES;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int HDR_UNITS = HEADER_BYTES / ALIGN_BYTES;
  localparam int SENT_IDX  = (ARENA_BYTES - HEADER_BYTES) / ALIGN_BYTES;
  localparam int INIT_SIZE = ARENA_BYTES - 2 * HEADER_BYTES;
  localparam int SPLIT_MIN = MIN_PAYLOAD + HEADER_BYTES;
  localparam int MAX_WALK  = ARENA_BYTES / (HEADER_BYTES + MIN_PAYLOAD) + 2;
  localparam int STEP_W    = $clog2(MAX_WALK + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SZ_W-1:0]  sz_t;

  typedef struct packed {
    logic bfree;
    sz_t  bsize;
    logic free;
    sz_t  size;
  } tag_t;

  typedef struct packed {
    idx_t next;
    logic nv;
    idx_t prev;
    logic pv;
  } link_t;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_ZERO  = 2'd1,
    RES_NOFIT = 2'd2
  } res_e;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_INIT0,
    OP_INIT1,
    OP_WALK_START,
    OP_WALK_READ,
    OP_WALK_CHK,
    OP_SPLIT_BASE,
    OP_SPLIT_TAIL,
    OP_SAVE_LINK,
    OP_LRD_NEXT,
    OP_LWR_NEXT,
    OP_LRD_PREV,
    OP_LWR_PREV,
    OP_HEAD_FROM_LSV,
    OP_TRD_CUR,
    OP_TRD_AUX,
    OP_TRD_AFT,
    OP_LRD_AUX,
    OP_LRD_AFT,
    OP_TWR_CUR_ALLOC,
    OP_TWR_CUR_FREE1,
    OP_TWR_CUR_MSZ,
    OP_TWR_AUX_BFREE0,
    OP_TWR_AUX_BFREE1,
    OP_TWR_AUX_BSZ,
    OP_TWR_AUX_MSZ,
    OP_FREE_START,
    OP_FREE_MARK,
    OP_AFT_CHK,
    OP_PUSH_WR,
    OP_LRD_HEAD,
    OP_LWR_HEAD,
    OP_HEAD_CUR,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    res_e code;
    logic offs;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic req_zero;
    logic rel_ok;
    logic walk_v;
    logic walk_end;
    logic fits;
    logic can_split;
    logic tag_free;
    logic tag_bfree;
    logic lrd_nv;
    logic lrd_pv;
    logic lsv_pv;
    logic head_v;
    logic out_busy;
  } stat_t;

  // Header that follows block b, given the payload size of b.
  function automatic idx_t hdr_after(idx_t b, sz_t sz);
    return b + idx_t'(HDR_UNITS) + idx_t'(sz >> GRAIN_SH);
  endfunction

  // Header that precedes block b, given the size of the block before it.
  function automatic idx_t hdr_before(idx_t b, sz_t bsz);
    return b - idx_t'(bsz >> GRAIN_SH) - idx_t'(HDR_UNITS);
  endfunction

endpackage

// File: hdl/btffa_dp.sv
// Datapath of the allocator: tag and link memories, working registers and result register.
module btffa_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  btffa_pkg::cmd_t   cmd_i,
  input  logic              in_fire_i,
  input  logic              func_i,
  input  logic [15:0]       request_bytes_i,
  input  logic [15:0]       release_offset_i,
  input  logic              out_ready_i,
  output btffa_pkg::stat_t  stat_o,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [15:0]       payload_offset_o
);
  import btffa_pkg::*;

  tag_t  tag_mem  [DEPTH];
  link_t link_mem [DEPTH];

  logic              func_q;
  sz_t               req_q, rel_q;
  logic [REQ_W-1:0]  size_q;
  idx_t              cur_q, cur_d, aux_q, aux_d, aft_q, aft_d, head_q, head_d;
  sz_t               csize_q, csize_d, msz_q, msz_d;
  logic              hv_q, hv_d, walk_v_q, walk_v_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  link_t             lsv_q, lsv_d;
  tag_t              td_q;
  link_t             lrd_q;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  sz_t               payload_q, payload_d;

  logic             t_we, t_re, l_we, l_re;
  idx_t             t_waddr, t_raddr, l_waddr, l_raddr;
  tag_t             t_wdata;
  link_t            l_wdata;
  logic [REQ_W-1:0] raised, rounded;
  sz_t              rsize;
  logic             out_busy;

  assign raised  = (request_bytes_i < SZ_W'(MIN_PAYLOAD)) ? REQ_W'(MIN_PAYLOAD)
                                                          : {1'b0, request_bytes_i};
  assign rounded = (raised + REQ_W'(ALIGN_BYTES - 1)) & ~REQ_W'(ALIGN_BYTES - 1);
  assign rsize   = td_q.size - size_q[SZ_W-1:0] - SZ_W'(HEADER_BYTES);
  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    stat_o.func      = func_q;
    stat_o.req_zero  = (req_q == '0);
    stat_o.rel_ok    = (rel_q >= SZ_W'(HEADER_BYTES));
    stat_o.walk_v    = walk_v_q;
    stat_o.walk_end  = (steps_q == STEP_W'(MAX_WALK));
    stat_o.fits      = ({1'b0, td_q.size} >= size_q);
    stat_o.can_split = ({2'b00, td_q.size} >= ({1'b0, size_q} + (REQ_W + 1)'(SPLIT_MIN)));
    stat_o.tag_free  = td_q.free;
    stat_o.tag_bfree = td_q.bfree;
    stat_o.lrd_nv    = lrd_q.nv;
    stat_o.lrd_pv    = lrd_q.pv;
    stat_o.lsv_pv    = lsv_q.pv;
    stat_o.head_v    = hv_q;
    stat_o.out_busy  = out_busy;
  end

  always_comb begin
    t_we = 1'b0; t_waddr = cur_q; t_wdata = td_q;
    t_re = 1'b0; t_raddr = cur_q;
    l_we = 1'b0; l_waddr = cur_q; l_wdata = lrd_q;
    l_re = 1'b0; l_raddr = cur_q;
    cur_d = cur_q; aux_d = aux_q; aft_d = aft_q; head_d = head_q; hv_d = hv_q;
    csize_d = csize_q; msz_d = msz_q; walk_v_d = walk_v_q; steps_d = steps_q;
    lsv_d = lsv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q; payload_d = payload_q;
    case (cmd_i.op)
      OP_INIT0: begin
        t_we = 1'b1; t_waddr = '0;
        t_wdata = '{bfree: 1'b0, bsize: '0, free: 1'b1, size: SZ_W'(INIT_SIZE)};
        l_we = 1'b1; l_waddr = '0; l_wdata = '0;
      end
      OP_INIT1: begin
        t_we = 1'b1; t_waddr = idx_t'(SENT_IDX);
        t_wdata = '{bfree: 1'b1, bsize: SZ_W'(INIT_SIZE), free: 1'b0, size: '0};
      end
      OP_WALK_START: begin
        cur_d = head_q; walk_v_d = hv_q; steps_d = '0;
      end
      OP_WALK_READ: begin
        t_re = 1'b1; l_re = 1'b1;
        steps_d = steps_q + 1'b1;
      end
      OP_WALK_CHK: begin
        lsv_d = lrd_q;
        if (!stat_o.fits) begin
          cur_d = lrd_q.next; walk_v_d = lrd_q.nv;
        end
      end
      OP_SPLIT_BASE: begin
        t_we = 1'b1; t_wdata.size = rsize;
        aux_d = hdr_after(cur_q, rsize); csize_d = rsize;
      end
      OP_SPLIT_TAIL: begin
        t_we = 1'b1; t_waddr = aux_q;
        t_wdata = '{bfree: 1'b1, bsize: csize_q, free: 1'b0, size: size_q[SZ_W-1:0]};
        cur_d = aux_q; aux_d = hdr_after(aux_q, size_q[SZ_W-1:0]);
        msz_d = size_q[SZ_W-1:0];
      end
      OP_SAVE_LINK:     lsv_d = lrd_q;
      OP_LRD_NEXT: begin
        l_re = 1'b1; l_raddr = lsv_q.next;
      end
      OP_LWR_NEXT: begin
        l_we = 1'b1; l_waddr = lsv_q.next;
        l_wdata.prev = lsv_q.prev; l_wdata.pv = lsv_q.pv;
      end
      OP_LRD_PREV: begin
        l_re = 1'b1; l_raddr = lsv_q.prev;
      end
      OP_LWR_PREV: begin
        l_we = 1'b1; l_waddr = lsv_q.prev;
        l_wdata.next = lsv_q.next; l_wdata.nv = lsv_q.nv;
      end
      OP_HEAD_FROM_LSV: begin
        head_d = lsv_q.next; hv_d = lsv_q.nv;
      end
      OP_TRD_CUR:       t_re = 1'b1;
      OP_TRD_AUX: begin
        t_re = 1'b1; t_raddr = aux_q;
      end
      OP_TRD_AFT: begin
        t_re = 1'b1; t_raddr = aft_q;
      end
      OP_LRD_AUX: begin
        l_re = 1'b1; l_raddr = aux_q;
      end
      OP_LRD_AFT: begin
        l_re = 1'b1; l_raddr = aft_q;
      end
      OP_TWR_CUR_ALLOC: begin
        t_we = 1'b1; t_wdata.free = 1'b0;
        aux_d = hdr_after(cur_q, td_q.size);
      end
      OP_TWR_CUR_FREE1: begin
        t_we = 1'b1; t_wdata.free = 1'b1;
        aux_d = hdr_after(cur_q, td_q.size);
      end
      OP_TWR_CUR_MSZ: begin
        t_we = 1'b1; t_wdata.size = msz_q;
        aux_d = hdr_after(cur_q, msz_q); csize_d = msz_q;
      end
      OP_TWR_AUX_BFREE0: begin
        t_we = 1'b1; t_waddr = aux_q; t_wdata.bfree = 1'b0;
      end
      OP_TWR_AUX_BFREE1: begin
        t_we = 1'b1; t_waddr = aux_q; t_wdata.bfree = 1'b1;
      end
      OP_TWR_AUX_BSZ: begin
        t_we = 1'b1; t_waddr = aux_q; t_wdata.bsize = msz_q;
      end
      OP_TWR_AUX_MSZ: begin
        t_we = 1'b1; t_waddr = aux_q; t_wdata.size = msz_q;
        cur_d = aux_q; csize_d = msz_q; aux_d = hdr_after(aux_q, msz_q);
      end
      OP_FREE_START:    cur_d = idx_t'((rel_q - SZ_W'(HEADER_BYTES)) >> GRAIN_SH);
      OP_FREE_MARK: begin
        aft_d = hdr_after(cur_q, td_q.size);
        aux_d = hdr_before(cur_q, td_q.bsize);
        msz_d = td_q.bsize + td_q.size + SZ_W'(HEADER_BYTES);
        csize_d = td_q.size;
      end
      OP_AFT_CHK:       msz_d = csize_q + td_q.size + SZ_W'(HEADER_BYTES);
      OP_PUSH_WR: begin
        l_we = 1'b1;
        l_wdata = '{next: head_q, nv: hv_q, prev: '0, pv: 1'b0};
      end
      OP_LRD_HEAD: begin
        l_re = 1'b1; l_raddr = head_q;
      end
      OP_LWR_HEAD: begin
        l_we = 1'b1; l_waddr = head_q;
        l_wdata.prev = cur_q; l_wdata.pv = 1'b1;
      end
      OP_HEAD_CUR: begin
        head_d = cur_q; hv_d = 1'b1;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          status_d = cmd_i.code;
          payload_d = cmd_i.offs ? (SZ_W'(cur_q) << GRAIN_SH) + SZ_W'(HEADER_BYTES) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tag_mem[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      td_q <= tag_mem[t_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      link_mem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      lrd_q <= link_mem[l_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      func_q <= func_i;
      req_q  <= request_bytes_i;
      rel_q  <= release_offset_i;
      size_q <= rounded;
    end
    cur_q <= cur_d; aux_q <= aux_d; aft_q <= aft_d;
    csize_q <= csize_d; msz_q <= msz_d; lsv_q <= lsv_d;
    steps_q <= steps_d;
    status_q <= status_d; payload_q <= payload_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      hv_q        <= 1'b1;
      walk_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      hv_q        <= hv_d;
      walk_v_q    <= walk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign payload_offset_o = payload_q;

endmodule

// File: hdl/btffa_ctrl.sv
// Sequencer of the allocator: issues one datapath command per cycle for each item.
module btffa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  btffa_pkg::stat_t stat_i,
  output btffa_pkg::cmd_t  cmd_o,
  output logic             in_ready_o
);
  import btffa_pkg::*;

  typedef enum logic [5:0] {
    S_INIT0, S_INIT1, S_IDLE, S_DISP,
    S_W_START, S_W_TEST, S_W_READ, S_W_CHK,
    S_SP_BASE, S_SP_TAIL, S_SP_RD, S_SP_WR,
    S_U_START, S_U_NRD, S_U_NWR, S_U_PRD, S_U_PWR, S_U_HEAD,
    S_A_RD, S_A_WR, S_A_RD2, S_A_WR2,
    S_F_START, S_F_RD, S_F_CHK,
    S_FB_LRD, S_FB_RD, S_FB_WR, S_FB_RD2, S_FB_WR2,
    S_FA_RD, S_FA_CHK, S_FA_LRD, S_FA_RD_CUR, S_FA_WR_CUR, S_FA_RD2, S_FA_WR2,
    S_FM_RD, S_FM_WR, S_FM_RD2, S_FM_WR2,
    S_P_WR, S_P_RD, S_P_WR2, S_P_HEAD,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CTX_ALLOC,
    CTX_BEF,
    CTX_AFT
  } ctx_e;

  state_e state_q, state_d, ret_state;
  ctx_e   ctx_q, ctx_d;
  cmd_t   cmd_q;
  res_e   code_d;
  logic   offs_d;
  logic   in_ready_q;

  function automatic op_e op_of(state_e s);
    op_e o;
    o = OP_NONE;
    unique case (s)
      S_INIT0:     o = OP_INIT0;
      S_INIT1:     o = OP_INIT1;
      S_W_START:   o = OP_WALK_START;
      S_W_READ:    o = OP_WALK_READ;
      S_W_CHK:     o = OP_WALK_CHK;
      S_SP_BASE:   o = OP_SPLIT_BASE;
      S_SP_TAIL:   o = OP_SPLIT_TAIL;
      S_SP_RD:     o = OP_TRD_AUX;
      S_SP_WR:     o = OP_TWR_AUX_BSZ;
      S_U_START:   o = OP_SAVE_LINK;
      S_U_NRD:     o = OP_LRD_NEXT;
      S_U_NWR:     o = OP_LWR_NEXT;
      S_U_PRD:     o = OP_LRD_PREV;
      S_U_PWR:     o = OP_LWR_PREV;
      S_U_HEAD:    o = OP_HEAD_FROM_LSV;
      S_A_RD:      o = OP_TRD_CUR;
      S_A_WR:      o = OP_TWR_CUR_ALLOC;
      S_A_RD2:     o = OP_TRD_AUX;
      S_A_WR2:     o = OP_TWR_AUX_BFREE0;
      S_F_START:   o = OP_FREE_START;
      S_F_RD:      o = OP_TRD_CUR;
      S_F_CHK:     o = OP_FREE_MARK;
      S_FB_LRD:    o = OP_LRD_AUX;
      S_FB_RD:     o = OP_TRD_AUX;
      S_FB_WR:     o = OP_TWR_AUX_MSZ;
      S_FB_RD2:    o = OP_TRD_AUX;
      S_FB_WR2:    o = OP_TWR_AUX_BSZ;
      S_FA_RD:     o = OP_TRD_AFT;
      S_FA_CHK:    o = OP_AFT_CHK;
      S_FA_LRD:    o = OP_LRD_AFT;
      S_FA_RD_CUR: o = OP_TRD_CUR;
      S_FA_WR_CUR: o = OP_TWR_CUR_MSZ;
      S_FA_RD2:    o = OP_TRD_AUX;
      S_FA_WR2:    o = OP_TWR_AUX_BSZ;
      S_FM_RD:     o = OP_TRD_CUR;
      S_FM_WR:     o = OP_TWR_CUR_FREE1;
      S_FM_RD2:    o = OP_TRD_AUX;
      S_FM_WR2:    o = OP_TWR_AUX_BFREE1;
      S_P_WR:      o = OP_PUSH_WR;
      S_P_RD:      o = OP_LRD_HEAD;
      S_P_WR2:     o = OP_LWR_HEAD;
      S_P_HEAD:    o = OP_HEAD_CUR;
      S_EMIT:      o = OP_EMIT;
      default:     o = OP_NONE;
    endcase
    return o;
  endfunction

  always_comb begin
    unique case (ctx_q)
      CTX_ALLOC: ret_state = S_A_RD;
      CTX_BEF:   ret_state = S_FB_RD;
      CTX_AFT:   ret_state = S_FA_RD_CUR;
      default:   ret_state = S_FA_RD_CUR;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    code_d  = cmd_q.code;
    offs_d  = cmd_q.offs;
    unique case (state_q)
      S_INIT0: state_d = S_INIT1;
      S_INIT1: state_d = S_IDLE;
      S_IDLE:  if (in_fire_i) state_d = S_DISP;
      S_DISP: begin
        if (!stat_i.func && stat_i.req_zero) begin
          state_d = S_EMIT; code_d = RES_ZERO; offs_d = 1'b0;
        end else if (!stat_i.func) begin
          state_d = S_W_START;
        end else if (!stat_i.rel_ok) begin
          state_d = S_EMIT; code_d = RES_OK; offs_d = 1'b0;
        end else begin
          state_d = S_F_START;
        end
      end
      S_W_START: state_d = S_W_TEST;
      S_W_TEST: begin
        if (!stat_i.walk_v || stat_i.walk_end) begin
          state_d = S_EMIT; code_d = RES_NOFIT; offs_d = 1'b0;
        end else begin
          state_d = S_W_READ;
        end
      end
      S_W_READ: state_d = S_W_CHK;
      S_W_CHK: begin
        if (stat_i.fits && stat_i.can_split) begin
          state_d = S_SP_BASE;
        end else if (stat_i.fits) begin
          state_d = S_U_START; ctx_d = CTX_ALLOC;
        end else begin
          state_d = S_W_TEST;
        end
      end
      S_SP_BASE: state_d = S_SP_TAIL;
      S_SP_TAIL: state_d = S_SP_RD;
      S_SP_RD:   state_d = S_SP_WR;
      S_SP_WR:   state_d = S_A_RD;
      S_U_START: begin
        if (stat_i.lrd_nv)      state_d = S_U_NRD;
        else if (stat_i.lrd_pv) state_d = S_U_PRD;
        else                    state_d = S_U_HEAD;
      end
      S_U_NRD: state_d = S_U_NWR;
      S_U_NWR: state_d = stat_i.lsv_pv ? S_U_PRD : S_U_HEAD;
      S_U_PRD: state_d = S_U_PWR;
      S_U_PWR: state_d = ret_state;
      S_U_HEAD: state_d = ret_state;
      S_A_RD:  state_d = S_A_WR;
      S_A_WR:  state_d = S_A_RD2;
      S_A_RD2: state_d = S_A_WR2;
      S_A_WR2: begin
        state_d = S_EMIT; code_d = RES_OK; offs_d = 1'b1;
      end
      S_F_START: state_d = S_F_RD;
      S_F_RD:    state_d = S_F_CHK;
      S_F_CHK: begin
        if (stat_i.tag_free) begin
          state_d = S_EMIT; code_d = RES_OK; offs_d = 1'b0;
        end else if (stat_i.tag_bfree) begin
          state_d = S_FB_LRD;
        end else begin
          state_d = S_FA_RD;
        end
      end
      S_FB_LRD: begin
        state_d = S_U_START; ctx_d = CTX_BEF;
      end
      S_FB_RD:  state_d = S_FB_WR;
      S_FB_WR:  state_d = S_FB_RD2;
      S_FB_RD2: state_d = S_FB_WR2;
      S_FB_WR2: state_d = S_FA_RD;
      S_FA_RD:  state_d = S_FA_CHK;
      S_FA_CHK: state_d = stat_i.tag_free ? S_FA_LRD : S_FM_RD;
      S_FA_LRD: begin
        state_d = S_U_START; ctx_d = CTX_AFT;
      end
      S_FA_RD_CUR: state_d = S_FA_WR_CUR;
      S_FA_WR_CUR: state_d = S_FA_RD2;
      S_FA_RD2:    state_d = S_FA_WR2;
      S_FA_WR2:    state_d = S_FM_RD;
      S_FM_RD:  state_d = S_FM_WR;
      S_FM_WR:  state_d = S_FM_RD2;
      S_FM_RD2: state_d = S_FM_WR2;
      S_FM_WR2: state_d = S_P_WR;
      S_P_WR:   state_d = stat_i.head_v ? S_P_RD : S_P_HEAD;
      S_P_RD:   state_d = S_P_WR2;
      S_P_WR2:  state_d = S_P_HEAD;
      S_P_HEAD: begin
        state_d = S_EMIT; code_d = RES_OK; offs_d = 1'b0;
      end
      S_EMIT:  if (!stat_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT0;
      ctx_q      <= CTX_ALLOC;
      cmd_q      <= '{op: OP_INIT0, code: RES_OK, offs: 1'b0};
      in_ready_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ctx_q      <= ctx_d;
      cmd_q      <= '{op: op_of(state_d), code: code_d, offs: offs_d};
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign cmd_o      = cmd_q;
  assign in_ready_o = in_ready_q;

endmodule

// File: hdl/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit allocator: sequencer plus datapath.
//
// This block manages one 64 KiB arena of boundary-tagged blocks with a doubly
// linked free list kept in two on-chip memories of 8192 entries, one entry per
// 8-byte granule. Each item is either an allocate (the request is raised to 8
// bytes and rounded up to a multiple of 8, then the free list is walked first
// fit, splitting off the tail of a large block or unlinking a block that only
// just fits) or a free (the block merges with free neighbours on either side
// and the result is pushed on the list head). Every item gives exactly one
// result item. The block works on one item at a time because every step is a
// read-modify-write of a tag or link memory. A zero-byte
// allocate, a free below the arena and a free of a block that is already
// free give their result without touching the list. An allocate starts the
// walk and reads each free-list node it visits, then unlinks and marks the
// chosen block or splits and marks it; the walk gives up after 2050 nodes with
// a no-fit result. After reset the block writes the initial block and then the
// end sentinel before it takes its first item. A finished result waits in an
// output register, so the next item is accepted while the result is still to
// be taken; that next result waits until the register is free.
module boundary_tag_first_fit_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] payload_offset_o
);
  import btffa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;

  // An item is taken only while the sequencer sits idle.
  assign in_fire = in_valid_i && in_ready_o;

  btffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  btffa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .in_fire_i        (in_fire),
    .func_i           (func_i),
    .request_bytes_i  (request_bytes_i),
    .release_offset_i (release_offset_i),
    .out_ready_i      (out_ready_i),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o)
  );

endmodule

// File: hdl/btffa_checker.sv
// Port-level checks of the allocator and the bind that attaches them.
module btffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [15:0] payload_offset_o
);
  import btffa_pkg::*;

  // One item at a time: an accepted item closes the input until it is done.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again straight after an item");

  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != RES_OK |-> payload_offset_o == '0)
    else $error("failed allocate carries an offset");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> payload_offset_o[GRAIN_SH-1:0] == '0)
    else $error("payload offset not aligned");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(payload_offset_o))
    else $error("stalled result changed");

endmodule

bind boundary_tag_first_fit_allocator btffa_checker u_btffa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .payload_offset_o (payload_offset_o)
);

// File: sim/testbench.sv
// Testbench for the boundary-tag first-fit allocator, with its own allocator model.
`timescale 1ns / 1ps

module testbench;
  import btffa_pkg::*;

  // Cycles without any accepted item before the run is given up.
  // The longest correct wait is a walk of about 2050 nodes.
  localparam int STALL_LIMIT = 20000;
  localparam int WALK_LIMIT  = ARENA_BYTES / (HEADER_BYTES + MIN_PAYLOAD) + 2;
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  typedef struct packed {
    res_e        status;
    logic [15:0] offset;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FN_ALLOC;
  logic [15:0] request_bytes = '0;
  logic [15:0] release_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] payload_offset;

  boundary_tag_first_fit_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .request_bytes_i (request_bytes),
    .release_offset_i(release_offset),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .payload_offset_o(payload_offset)
  );

  always #10 clk_i = ~clk_i;

  // The arena model: every store is indexed by the byte offset of a header,
  // and all offset arithmetic wraps at 16 bits just as the arena does.
  bit          hdr_free [ARENA_BYTES];
  bit          hdr_bfree[ARENA_BYTES];
  logic [15:0] hdr_size [ARENA_BYTES];
  logic [15:0] hdr_bsize[ARENA_BYTES];
  logic [15:0] lst_next [ARENA_BYTES];
  logic [15:0] lst_prev [ARENA_BYTES];
  bit          lst_nv   [ARENA_BYTES];
  bit          lst_pv   [ARENA_BYTES];
  logic [15:0] list_head;
  bit          list_head_v;

  alloc_result_t pending_results[$];
  logic [15:0]   live_payloads[$];
  logic [15:0]   freed_payloads[$];
  int            mismatches = 0;
  int            failures = 0;
  int            quiet_cycles = 0;
  int            ready_gap = 0;
  bit            idling_on = 1'b1;

  function automatic logic [15:0] hdr_next(logic [15:0] b);
    return b + 16'(HEADER_BYTES) + hdr_size[b];
  endfunction

  function automatic logic [15:0] hdr_prev(logic [15:0] b);
    return b - hdr_bsize[b] - 16'(HEADER_BYTES);
  endfunction

  task automatic list_remove(logic [15:0] b);
    logic [15:0] nx, pr;
    bit nv, pv;
    nx = lst_next[b];
    pr = lst_prev[b];
    nv = lst_nv[b];
    pv = lst_pv[b];
    if (nv) begin
      lst_prev[nx] = pr;
      lst_pv[nx] = pv;
    end
    if (pv) begin
      lst_next[pr] = nx;
      lst_nv[pr] = nv;
    end else begin
      list_head = nx;
      list_head_v = nv;
    end
  endtask

  task automatic list_push(logic [15:0] b);
    lst_next[b] = list_head;
    lst_nv[b] = list_head_v;
    lst_pv[b] = 1'b0;
    lst_prev[b] = '0;
    if (list_head_v) begin
      lst_prev[list_head] = b;
      lst_pv[list_head] = 1'b1;
    end
    list_head = b;
    list_head_v = 1'b1;
  endtask

  task automatic arena_reset();
    logic [15:0] s;
    for (int i = 0; i < ARENA_BYTES; i++) begin
      hdr_free[i] = 0; hdr_bfree[i] = 0; hdr_size[i] = '0; hdr_bsize[i] = '0;
      lst_next[i] = '0; lst_prev[i] = '0; lst_nv[i] = 0; lst_pv[i] = 0;
    end
    hdr_free[0] = 1'b1;
    hdr_size[0] = 16'(INIT_SIZE);
    s = hdr_next(16'd0);
    hdr_bfree[s] = 1'b1;
    hdr_bsize[s] = 16'(INIT_SIZE);
    list_head = '0;
    list_head_v = 1'b1;
  endtask

  // Works out the result of one item and updates the arena model.
  task automatic arena_apply(input logic fn, input logic [15:0] req, input logic [15:0] rel,
                             output alloc_result_t res);
    int need, bs;
    logic [15:0] p, t, a, b, aft, bef;
    bit pv, found;
    res.status = RES_OK;
    res.offset = '0;
    found = 1'b0;
    if (fn == FN_ALLOC) begin
      if (req == 0) begin
        res.status = RES_ZERO;
        return;
      end
      need = (req < MIN_PAYLOAD) ? MIN_PAYLOAD : int'(req);
      if (need % ALIGN_BYTES != 0) need += ALIGN_BYTES - need % ALIGN_BYTES;
      p = list_head;
      pv = list_head_v;
      for (int steps = 0; pv && steps < WALK_LIMIT && !found; steps++) begin
        bs = hdr_size[p];
        if (bs >= need) begin
          found = 1'b1;
          if (bs >= MIN_PAYLOAD + HEADER_BYTES + need) begin
            // Large block: the tail is cut off and the head stays listed.
            hdr_size[p] = 16'(bs - need - HEADER_BYTES);
            t = hdr_next(p);
            hdr_bsize[t] = hdr_size[p];
            hdr_bfree[t] = 1'b1;
            hdr_size[t] = 16'(need);
            hdr_free[t] = 1'b0;
            a = hdr_next(t);
            hdr_bsize[a] = 16'(need);
            hdr_bfree[a] = 1'b0;
            p = t;
          end else begin
            list_remove(p);
          end
        end else begin
          pv = lst_nv[p];
          p = lst_next[p];
        end
      end
      if (!found) begin
        res.status = RES_NOFIT;
        return;
      end
      hdr_free[p] = 1'b0;
      hdr_bfree[hdr_next(p)] = 1'b0;
      res.offset = p + 16'(HEADER_BYTES);
      return;
    end
    // Null and below-arena offsets are ignored, as is a block already free.
    if (rel < HEADER_BYTES) return;
    b = rel - 16'(HEADER_BYTES);
    if (hdr_free[b]) return;
    aft = hdr_next(b);
    if (hdr_bfree[b]) begin
      bef = hdr_prev(b);
      list_remove(bef);
      hdr_size[bef] = hdr_bsize[b] + hdr_size[b] + 16'(HEADER_BYTES);
      b = bef;
      hdr_bsize[hdr_next(b)] = hdr_size[b];
    end
    if (hdr_free[aft]) begin
      list_remove(aft);
      hdr_size[b] = hdr_size[b] + hdr_size[aft] + 16'(HEADER_BYTES);
      hdr_bsize[hdr_next(b)] = hdr_size[b];
    end
    hdr_free[b] = 1'b1;
    hdr_bfree[hdr_next(b)] = 1'b1;
    list_push(b);
  endtask

  // Sends one item, starting at a falling edge and returning at the falling
  // edge after it was taken. Valid is only lowered here for an idle burst.
  task automatic send_item(logic fn, logic [15:0] req, logic [15:0] rel);
    alloc_result_t res;
    if (idling_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    func <= fn;
    request_bytes <= req;
    release_offset <= rel;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    arena_apply(fn, req, rel, res);
    pending_results.push_back(res);
    if (fn == FN_ALLOC && res.status == RES_OK) live_payloads.push_back(res.offset);
    @(negedge clk_i);
  endtask

  task automatic alloc_item(int unsigned req);
    send_item(FN_ALLOC, 16'(req), 16'($urandom));
  endtask

  task automatic free_item(logic [15:0] rel);
    send_item(FN_FREE, 16'($urandom), rel);
  endtask

  // Frees a random live block and remembers it for a later double free.
  task automatic free_live_block();
    int k;
    logic [15:0] off;
    k = $urandom_range(live_payloads.size() - 1);
    off = live_payloads[k];
    live_payloads.delete(k);
    free_item(off);
    freed_payloads.push_back(off);
    if (freed_payloads.size() > 16) void'(freed_payloads.pop_front());
  endtask

  // A second free is only sent while the header still reads free; once its
  // block has been merged into a predecessor the header is stale.
  task automatic double_free();
    logic [15:0] off;
    if (freed_payloads.size() == 0) return;
    off = freed_payloads[$urandom_range(freed_payloads.size() - 1)];
    if (hdr_free[off - 16'(HEADER_BYTES)]) free_item(off);
  endtask

  task automatic release_all();
    while (live_payloads.size() > 0) free_live_block();
  endtask

  // Each result is taken at the rising edge and matched to the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("Unexpected result item: status %0d offset %0d",
                                      status, payload_offset);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || payload_offset !== want.offset) begin
          failures++;
          if (mismatches < 10)
            $display("Mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                     want.status, want.offset, status, payload_offset);
          mismatches++;
        end
      end
    end
  end

  // The receiver stalls in random bursts while idling is on, and is ready
  // again between bursts.
  always @(negedge clk_i) begin
    if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if (idling_on && out_ready && $urandom_range(4) == 0) begin
      out_ready <= 1'b0;
      ready_gap <= $urandom_range(3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_reset();
    arena_reset();
    rst_ni <= 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
  endtask

  // Field extremes, every operation and each special case, including a free
  // that merges on both sides.
  task automatic test_directed();
    logic [15:0] a, b, c;
    alloc_item(0);
    alloc_item(65535);
    alloc_item(INIT_SIZE);
    alloc_item(8);
    free_item(live_payloads.pop_back());
    alloc_item(1);
    alloc_item(9);
    free_item(16'd0);
    free_item(16'd23);
    release_all();
    alloc_item(100);
    alloc_item(200);
    alloc_item(300);
    alloc_item(16);
    a = live_payloads[0]; b = live_payloads[1]; c = live_payloads[2];
    free_item(a);
    free_item(a);
    free_item(c);
    free_item(c);
    free_item(b);
    live_payloads = live_payloads[3:$];
    release_all();
    alloc_item(32768);
    alloc_item(32768);
    release_all();
  endtask

  // Random mix: mostly small allocations and frees of live blocks, with
  // occasional large requests, ignored frees and full releases.
  task automatic test_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45 || live_payloads.size() == 0) begin
        case ($urandom_range(9))
          0:       alloc_item($urandom_range(65535));
          1:       alloc_item($urandom_range(1, 8192));
          2:       alloc_item(0);
          default: alloc_item($urandom_range(1, 400));
        endcase
      end else if (pick < 88) begin
        free_live_block();
      end else if (pick < 93) begin
        double_free();
      end else if (pick < 97) begin
        free_item(16'($urandom_range(HEADER_BYTES - 1)));
      end else if (pick < 98) begin
        release_all();
      end else begin
        alloc_item(INIT_SIZE - $urandom_range(64));
      end
    end
  endtask

  task automatic test_drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    test_reset();
    test_directed();
    test_random(1300);
    idling_on = 1'b0;
    test_random(300);
    release_all();
    test_drain();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
